// ===== hw/rtl/mfmtf_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT byte step for the MFM track formatter.
`default_nettype none

package mfmtf_pkg;

    // Track geometry
    localparam int TRACK_BYTES = 6250;
    localparam int TABLE_BYTES = 128;
    localparam int TOTAL_BYTES = TABLE_BYTES + TRACK_BYTES;
    localparam int POS_W       = $clog2(TOTAL_BYTES);
    localparam int ID_W        = 18;

    // Item operation codes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_PULL  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_SPT   = 3'd0;
    localparam logic [2:0] REG_SIZE  = 3'd1;
    localparam logic [2:0] REG_GAP3  = 3'd2;
    localparam logic [2:0] REG_GAP1  = 3'd3;
    localparam logic [2:0] REG_GAP2  = 3'd4;
    localparam logic [2:0] REG_GAP4A = 3'd5;

    // Mark and filler bytes
    localparam logic [7:0] BYTE_GAP   = 8'h4e;
    localparam logic [7:0] BYTE_SYNC  = 8'h00;
    localparam logic [7:0] BYTE_IAM   = 8'hc2;
    localparam logic [7:0] BYTE_INDEX = 8'hfc;
    localparam logic [7:0] BYTE_A1    = 8'ha1;
    localparam logic [7:0] BYTE_IDAM  = 8'hfe;
    localparam logic [7:0] BYTE_DAM   = 8'hfb;
    localparam logic [7:0] BYTE_HIBIT = 8'h80;
    localparam logic [15:0] CRC_INIT  = 16'hffff;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef struct packed {
        logic [6:0] spt;
        logic [1:0] size;
        logic [7:0] gap3;
        logic [7:0] gap1;
        logic [7:0] gap2;
        logic [7:0] gap4a;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [7:0] cylinder;
        logic [7:0] head;
        logic [7:0] data_byte;
    } item_t;

    // One byte through CRC-16/CCITT, MSB first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mfmtf_front.sv =====
// Front end: accepts items, decodes the operation and holds them in a two-entry queue.
`default_nettype none

module mfmtf_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            mode,
    input  wire logic [7:0]      cylinder,
    input  wire logic [7:0]      head,
    input  wire logic [7:0]      data_byte,
    output logic                 q_valid,
    output mfmtf_pkg::item_t     q_item,
    input  wire logic            q_pop
);

    mfmtf_pkg::item_t q_mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    mfmtf_pkg::item_t new_item;

    // Classify the incoming item
    always_comb
    begin
        new_item.op        = mode ? mfmtf_pkg::OP_PULL : mfmtf_pkg::OP_BEGIN;
        new_item.cylinder  = cylinder;
        new_item.head      = head;
        new_item.data_byte = data_byte;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/mfmtf_back.sv =====
// Back end: track byte sequencer with CRC, table offsets and the output register.
`default_nettype none

module mfmtf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mfmtf_pkg::cfg_t  cfg,
    input  wire logic             q_valid,
    input  wire mfmtf_pkg::item_t q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            track_byte,
    output logic                  data_taken,
    output logic                  last,
    output logic                  layout_error
);

    localparam int POS_W = mfmtf_pkg::POS_W;
    localparam int ID_W  = mfmtf_pkg::ID_W;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_TABLE = 2'd1;
    localparam logic [1:0] PH_HEAD  = 2'd2;
    localparam logic [1:0] PH_SECT  = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [10:0]      off_reg, off_next;
    logic [7:0]       sec_reg, sec_next;
    logic [15:0]      crc_reg, crc_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [7:0]       cyl_reg, cyl_next;
    logic [7:0]       hd_reg, hd_next;
    logic [6:0]       spt_reg, spt_next;
    logic [1:0]       size_reg, size_next;
    logic [7:0]       gap4a_reg, gap4a_next;
    logic [10:0]      raw_reg, raw_next;
    logic [9:0]       hlen_reg, hlen_next;
    logic [8:0]       dstart_reg, dstart_next;
    logic [10:0]      dend_reg, dend_next;

    logic             ovalid_reg, ovalid_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             otaken_reg, otaken_next;
    logic             olast_reg, olast_next;
    logic             oerr_reg, oerr_next;

    logic             advance;
    logic             take;
    logic [10:0]      sbytes;
    logic [POS_W-1:0] t;
    logic [POS_W-1:0] g4;
    logic [POS_W-1:0] e;
    logic [10:0]      ds;
    logic             sec_live;
    logic             is_last;
    logic [7:0]       b;
    logic             taken;
    logic             crc_en;
    logic [15:0]      crc_base;

    assign advance = !ovalid_reg || out_ready;
    assign take    = q_valid && advance;
    assign q_pop   = take;

    assign sbytes   = 11'd128 << cfg.size;
    assign t        = pos_reg - POS_W'(mfmtf_pkg::TABLE_BYTES);
    assign g4       = POS_W'(gap4a_reg);
    assign e        = pos_reg >> 1;
    assign ds       = 11'(dstart_reg);
    assign sec_live = sec_reg < {1'b0, spt_reg};
    assign is_last  = pos_reg == POS_W'(mfmtf_pkg::TOTAL_BYTES - 1);

    // Byte selection for the current position
    always_comb
    begin
        b        = mfmtf_pkg::BYTE_SYNC;
        taken    = 1'b0;
        crc_en   = 1'b0;
        crc_base = crc_reg;
        case (phase_reg)
            PH_TABLE:
            begin
                if ((e < POS_W'(spt_reg))
                    && ((pos_reg | POS_W'(1)) < POS_W'(mfmtf_pkg::TABLE_BYTES))
                    && (id_reg < ID_W'(mfmtf_pkg::TOTAL_BYTES)))
                begin
                    b = pos_reg[0] ? (mfmtf_pkg::BYTE_HIBIT | {1'b0, id_reg[14:8]})
                                   : id_reg[7:0];
                end
            end
            PH_HEAD:
            begin
                if (t < g4)
                    b = mfmtf_pkg::BYTE_GAP;
                else if (t < g4 + POS_W'(12))
                    b = mfmtf_pkg::BYTE_SYNC;
                else if (t < g4 + POS_W'(15))
                    b = mfmtf_pkg::BYTE_IAM;
                else if (t < g4 + POS_W'(16))
                    b = mfmtf_pkg::BYTE_INDEX;
                else
                    b = mfmtf_pkg::BYTE_GAP;
            end
            PH_SECT:
            begin
                if (!sec_live)
                    b = mfmtf_pkg::BYTE_GAP;
                else if (off_reg < 11'd12)
                    b = mfmtf_pkg::BYTE_SYNC;
                else if (off_reg < 11'd15)
                begin
                    b      = mfmtf_pkg::BYTE_A1;
                    crc_en = 1'b1;
                    if (off_reg == 11'd12)
                        crc_base = mfmtf_pkg::CRC_INIT;
                end
                else if (off_reg < 11'd20)
                begin
                    crc_en = 1'b1;
                    if (off_reg == 11'd15)
                        b = mfmtf_pkg::BYTE_IDAM;
                    else if (off_reg == 11'd16)
                        b = cyl_reg;
                    else if (off_reg == 11'd17)
                        b = hd_reg;
                    else if (off_reg == 11'd18)
                        b = sec_reg + 8'd1;
                    else
                        b = {6'd0, size_reg};
                end
                else if (off_reg == 11'd20)
                    b = crc_reg[15:8];
                else if (off_reg == 11'd21)
                    b = crc_reg[7:0];
                else if (off_reg < ds)
                    b = mfmtf_pkg::BYTE_GAP;
                else if (off_reg < ds + 11'd12)
                    b = mfmtf_pkg::BYTE_SYNC;
                else if (off_reg < ds + 11'd15)
                begin
                    b      = mfmtf_pkg::BYTE_A1;
                    crc_en = 1'b1;
                    if (off_reg == ds + 11'd12)
                        crc_base = mfmtf_pkg::CRC_INIT;
                end
                else if (off_reg == ds + 11'd15)
                begin
                    b      = mfmtf_pkg::BYTE_DAM;
                    crc_en = 1'b1;
                end
                else if (off_reg < dend_reg)
                begin
                    b      = q_item.data_byte;
                    taken  = 1'b1;
                    crc_en = 1'b1;
                end
                else if (off_reg == dend_reg)
                    b = crc_reg[15:8];
                else if (off_reg == dend_reg + 11'd1)
                    b = crc_reg[7:0];
                else
                    b = mfmtf_pkg::BYTE_GAP;
            end
            default:
            begin
                b = mfmtf_pkg::BYTE_SYNC;
            end
        endcase
    end

    // Sequencer state update
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        off_next    = off_reg;
        sec_next    = sec_reg;
        crc_next    = crc_reg;
        id_next     = id_reg;
        cyl_next    = cyl_reg;
        hd_next     = hd_reg;
        spt_next    = spt_reg;
        size_next   = size_reg;
        gap4a_next  = gap4a_reg;
        raw_next    = raw_reg;
        hlen_next   = hlen_reg;
        dstart_next = dstart_reg;
        dend_next   = dend_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next  = obyte_reg;
        otaken_next = otaken_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;

        if (take && q_item.op == mfmtf_pkg::OP_BEGIN)
        begin
            // Latch configuration and derived lengths for the new track
            cyl_next    = q_item.cylinder;
            hd_next     = q_item.head;
            spt_next    = cfg.spt;
            size_next   = cfg.size;
            gap4a_next  = cfg.gap4a;
            raw_next    = 11'd40 + 11'(cfg.gap2) + sbytes + 11'(cfg.gap3);
            hlen_next   = 10'(cfg.gap4a) + 10'd16 + 10'(cfg.gap1);
            dstart_next = 9'(cfg.gap2) + 9'd22;
            dend_next   = 11'(cfg.gap2) + 11'd38 + sbytes;
            id_next     = ID_W'(mfmtf_pkg::TABLE_BYTES + 15) + ID_W'(cfg.gap4a)
                          + ID_W'(cfg.gap1) + ID_W'(16);
            phase_next  = PH_TABLE;
            pos_next    = '0;
            off_next    = '0;
            sec_next    = '0;
            crc_next    = mfmtf_pkg::CRC_INIT;
        end
        else if (take && phase_reg != PH_IDLE)
        begin
            // Emit one byte
            ovalid_next = 1'b1;
            obyte_next  = b;
            otaken_next = taken;
            olast_next  = is_last;
            oerr_next   = is_last && sec_live
                          && !((sec_reg + 8'd1 == {1'b0, spt_reg})
                               && (off_reg == raw_reg - 11'd1));
            if (crc_en)
                crc_next = mfmtf_pkg::crc_step(crc_base, b);

            case (phase_reg)
                PH_TABLE:
                begin
                    if (pos_reg[0])
                        id_next = id_reg + ID_W'(raw_reg);
                    if (pos_reg == POS_W'(mfmtf_pkg::TABLE_BYTES - 1))
                        phase_next = PH_HEAD;
                end
                PH_HEAD:
                begin
                    if (t == POS_W'(hlen_reg) - POS_W'(1))
                    begin
                        phase_next = PH_SECT;
                        off_next   = '0;
                        sec_next   = '0;
                    end
                end
                PH_SECT:
                begin
                    if (off_reg == raw_reg - 11'd1)
                    begin
                        off_next = '0;
                        sec_next = sec_reg + 8'd1;
                    end
                    else
                    begin
                        off_next = off_reg + 11'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (is_last)
            begin
                phase_next = PH_IDLE;
                pos_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            off_reg    <= '0;
            sec_reg    <= '0;
            crc_reg    <= mfmtf_pkg::CRC_INIT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            off_reg    <= off_next;
            sec_reg    <= sec_next;
            crc_reg    <= crc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Latched track parameters and output payload
    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        cyl_reg    <= cyl_next;
        hd_reg     <= hd_next;
        spt_reg    <= spt_next;
        size_reg   <= size_next;
        gap4a_reg  <= gap4a_next;
        raw_reg    <= raw_next;
        hlen_reg   <= hlen_next;
        dstart_reg <= dstart_next;
        dend_reg   <= dend_next;
        obyte_reg  <= obyte_next;
        otaken_reg <= otaken_next;
        olast_reg  <= olast_next;
        oerr_reg   <= oerr_next;
    end

    assign out_valid    = ovalid_reg;
    assign track_byte   = obyte_reg;
    assign data_taken   = otaken_reg;
    assign last         = olast_reg;
    assign layout_error = oerr_reg;

    a_err_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && oerr_reg |-> olast_reg)
        else $error("layout error flagged before the last byte");

    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> pos_reg == '0)
        else $error("position not cleared while idle");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg != PH_IDLE && q_item.op == mfmtf_pkg::OP_PULL && is_last
        |=> phase_reg == PH_IDLE)
        else $error("sequencer did not return to idle after the last byte");

endmodule

`default_nettype wire

// ===== hw/rtl/mfm_track_formatter_unit.sv =====
// MFM track formatter top level: configuration registers, front queue and back sequencer.
// Path: a pull transfer is held in the front queue and then in the output register before
// its track byte shows at the output, when the queue was empty and the output register free.
// Throughput: one item per cycle unless out_ready stalls the output; the back sequencer
// emits one byte per cycle from counters and a bytewise CRC; a begin item emits no byte.
// Reset: configuration returns to its defaults, the queue empties and the sequencer idles.
`default_nettype none

module mfm_track_formatter_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       mode,
    input  wire logic [7:0] cylinder,
    input  wire logic [7:0] head,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      track_byte,
    output logic            data_taken,
    output logic            last,
    output logic            layout_error
);

    mfmtf_pkg::cfg_t  cfg_reg, cfg_next;
    logic             q_valid;
    logic             q_pop;
    mfmtf_pkg::item_t q_item;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                mfmtf_pkg::REG_SPT:   cfg_next.spt   = cfg_data[6:0];
                mfmtf_pkg::REG_SIZE:  cfg_next.size  = cfg_data[1:0];
                mfmtf_pkg::REG_GAP3:  cfg_next.gap3  = cfg_data;
                mfmtf_pkg::REG_GAP1:  cfg_next.gap1  = cfg_data;
                mfmtf_pkg::REG_GAP2:  cfg_next.gap2  = cfg_data;
                mfmtf_pkg::REG_GAP4A: cfg_next.gap4a = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spt   <= 7'd17;
            cfg_reg.size  <= 2'd1;
            cfg_reg.gap3  <= 8'd34;
            cfg_reg.gap1  <= 8'd50;
            cfg_reg.gap2  <= 8'd22;
            cfg_reg.gap4a <= 8'd80;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mfmtf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .cylinder  (cylinder),
        .head      (head),
        .data_byte (data_byte),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    mfmtf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .track_byte   (track_byte),
        .data_taken   (data_taken),
        .last         (last),
        .layout_error (layout_error)
    );

endmodule

`default_nettype wire
